// File: hw/rtl/sset_pkg.sv
// Shared types, constants and helpers for the sorted sparse entry table.
// No dependencies; used by every module of the block.
`default_nettype none

package sset_pkg;

    // Table geometry
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int ROW_W     = 16;
    localparam int COL_W     = 16;
    localparam int VAL_W     = 64;
    localparam int IDX_W     = 6;
    localparam int EXT_W     = 17;
    localparam int STAT_W    = 3;
    localparam int CNT_OUT_W = 7;

    // One bit per table position
    typedef logic [CAPACITY-1:0] t_vec;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_ROW_ABSENT = 3'd1,
        ST_DUP_COL    = 3'd2,
        ST_FULL       = 3'd3,
        ST_BAD_INDEX  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_entry;

    // Per-cell write control
    typedef struct packed {
        logic load;   // take the new entry
        logic shift;  // take the lower neighbor's entry
    } t_cell_ctl;

    // Per-cell compare results, captured with the request
    typedef struct packed {
        logic eq;     // cell row equals request row
        logic below;  // cell col below request col
        logic above;  // cell col above request col
        logic hit;    // cell position equals read index
    } t_cell_flags;

    // Compare results of the whole row of cells
    typedef struct packed {
        t_vec eq;
        t_vec below;
        t_vec above;
    } t_match;

    // Lowest set bit of a vector, as a one-hot vector
    function automatic t_vec lowest_bit(input t_vec x);
        return x & (~x + t_vec'(1));
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sset_cell.sv
// One table position: holds an entry and its compare flags.
// Depends on sset_pkg.
`default_nettype none

module sset_cell
    import sset_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_capture,
    input  wire t_entry      i_req,
    input  wire logic        i_hit,
    input  wire t_cell_ctl   i_ctl,
    input  wire t_entry      i_prev,
    output t_entry           o_entry,
    output t_cell_flags      o_flags
);

    t_entry      r_entry;
    t_cell_flags r_flags;

    // Entry storage: load new, shift up from neighbor, or hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_req;
        end else if (i_ctl.shift) begin
            r_entry <= i_prev;
        end
    end

    // Local compares against the request, taken when it is accepted
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_flags.eq    <= (r_entry.row == i_req.row);
            r_flags.below <= (r_entry.col < i_req.col);
            r_flags.above <= (r_entry.col > i_req.col);
            r_flags.hit   <= i_hit;
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

// File: hw/rtl/sset_chain.sv
// Row of table cells with neighbor shift path and one-hot read tree.
// Depends on sset_pkg and sset_cell.
`default_nettype none

module sset_chain
    import sset_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_capture,
    input  wire t_entry           i_req,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic             i_we,
    input  wire t_vec             i_pos,
    output t_match                o_match,
    output t_entry                o_rd
);

    t_entry      w_entry [CAPACITY];
    t_entry      w_prev  [CAPACITY];
    t_cell_ctl   w_ctl   [CAPACITY];
    t_cell_flags w_flags [CAPACITY];
    t_vec        w_hit;
    t_vec        w_shift;

    // Everything above the insert position moves up one place
    assign w_shift = ~(i_pos - t_vec'(1)) & ~i_pos;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam int K = k;

        assign w_hit[k]       = (K < (1 << IDX_W)) && (32'(i_index) == K);
        assign w_ctl[k].load  = i_we & i_pos[k];
        assign w_ctl[k].shift = i_we & w_shift[k];

        if (k == 0) begin : g_first
            assign w_prev[k] = i_req;
        end else begin : g_next
            assign w_prev[k] = w_entry[k-1];
        end

        assign o_match.eq[k]    = w_flags[k].eq;
        assign o_match.below[k] = w_flags[k].below;
        assign o_match.above[k] = w_flags[k].above;

        sset_cell u_cell (
            .i_clk     (i_clk),
            .i_capture (i_capture),
            .i_req     (i_req),
            .i_hit     (w_hit[k]),
            .i_ctl     (w_ctl[k]),
            .i_prev    (w_prev[k]),
            .o_entry   (w_entry[k]),
            .o_flags   (w_flags[k])
        );
    end

    // Read: at most one cell flagged, so an OR of gated entries
    always_comb begin
        t_entry acc;
        acc = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            acc = acc | (w_flags[k].hit ? w_entry[k] : t_entry'('0));
        end
        o_rd = acc;
    end

endmodule

`default_nettype wire

// File: hw/rtl/sset_place.sv
// Decides status and write position from the captured cell flags.
// Depends on sset_pkg.
`default_nettype none

module sset_place
    import sset_pkg::*;
(
    input  wire t_mode            i_mode,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire t_match           i_match,
    output t_status               o_status,
    output t_vec                  o_pos
);

    t_vec w_valid;
    t_vec w_tail;
    t_vec w_row;
    t_vec w_start;
    t_vec w_after;
    t_vec w_gap;
    t_vec w_end;
    t_vec w_run;
    t_vec w_last;
    t_vec w_cand;
    t_vec w_ins;
    logic w_row_found;
    logic w_first;
    logic w_past;
    logic w_between;
    logic w_full;
    logic w_bad_idx;

    // Occupied positions and the first free one
    for (genvar k = 0; k < CAPACITY; k++) begin : g_pos
        localparam int K = k;
        assign w_valid[k] = (32'(i_count) > K);
        assign w_tail[k]  = (32'(i_count) == K);
    end

    // First run of the request row
    assign w_row       = w_valid & i_match.eq;
    assign w_row_found = |w_row;
    assign w_start     = lowest_bit(w_row);
    assign w_after     = ~(w_start - t_vec'(1));
    assign w_gap       = w_after & ~w_row;
    assign w_end       = lowest_bit(w_gap);
    assign w_run       = w_after & (w_end - t_vec'(1));
    assign w_last      = w_run & ~(w_run >> 1);

    // Placement: before the run, after it, or in the first fitting gap
    assign w_first   = |(w_start & i_match.above);
    assign w_past    = |(w_last & i_match.below);
    assign w_cand    = ((w_run & i_match.below) << 1) & w_run & i_match.above;
    assign w_between = |w_cand;
    assign w_ins     = w_first ? w_start : (w_past ? w_end : lowest_bit(w_cand));

    assign w_full    = (32'(i_count) >= CAPACITY);
    assign w_bad_idx = (32'(i_index) >= 32'(i_count));

    always_comb begin
        o_status = ST_OK;
        o_pos    = w_tail;
        case (i_mode)
            MODE_CLEAR: begin
                o_status = ST_OK;
            end
            MODE_APPEND: begin
                if (w_full) o_status = ST_FULL;
            end
            MODE_INSERT: begin
                o_pos = w_ins;
                if (!w_row_found) begin
                    o_status = ST_ROW_ABSENT;
                end else if (!(w_first || w_past || w_between)) begin
                    o_status = ST_DUP_COL;
                end else if (w_full) begin
                    o_status = ST_FULL;
                end
            end
            MODE_READ: begin
                if (w_bad_idx) o_status = ST_BAD_INDEX;
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_sparse_entry_table_core.sv
// Sorted sparse entry table: cell chain with append, sorted insert and read.
// Result: registered when a request commits; an output stall can hold the commit.
// One request at a time: the input stalls until the request commits; cells compare
// on the accept edge, placement, shift and count/extent update happen on the commit edge.
// Reset: count 0, extents 1, no result pending; entry storage is not cleared.
// Depends on sset_pkg, sset_chain and sset_place.
`default_nettype none

module sorted_sparse_entry_table_core
    import sset_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_mode,
    input  wire logic [ROW_W-1:0]     i_row,
    input  wire logic [COL_W-1:0]     i_col,
    input  wire logic [VAL_W-1:0]     i_value,
    input  wire logic [IDX_W-1:0]     i_index,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [STAT_W-1:0]         o_status,
    output logic [CNT_OUT_W-1:0]      o_entry_count,
    output logic [EXT_W-1:0]          o_row_extent,
    output logic [EXT_W-1:0]          o_col_extent,
    output logic [ROW_W-1:0]          o_read_row,
    output logic [COL_W-1:0]          o_read_col,
    output logic [VAL_W-1:0]          o_read_value
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [EXT_W-1:0] r_row_span, n_row_span;
    logic [EXT_W-1:0] r_col_span, n_col_span;
    logic             r_out_valid, n_out_valid;

    t_mode            r_mode;
    t_entry           r_req;
    logic [IDX_W-1:0] r_index;

    t_status          r_status;
    t_entry           r_rd;

    logic             w_accept;
    logic             w_commit;
    logic             w_we;
    logic             w_add;
    t_entry           w_req;
    t_match           w_match;
    t_entry           w_rd;
    t_status          w_status;
    t_vec             w_pos;
    logic [EXT_W-1:0] w_row_p1;
    logic [EXT_W-1:0] w_col_p1;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_commit   = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign w_add      = (r_mode == MODE_APPEND) || (r_mode == MODE_INSERT);
    assign w_we       = w_commit && w_add && (w_status == ST_OK);

    // The cells see the live request on the accept edge
    assign w_req = w_accept ? t_entry'{row: i_row, col: i_col, value: i_value} : r_req;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= t_mode'(i_mode);
            r_req   <= w_req;
            r_index <= i_index;
        end
    end

    sset_chain u_chain (
        .i_clk     (i_clk),
        .i_capture (w_accept),
        .i_req     (w_req),
        .i_index   (w_accept ? i_index : r_index),
        .i_we      (w_we),
        .i_pos     (w_pos),
        .o_match   (w_match),
        .o_rd      (w_rd)
    );

    sset_place u_place (
        .i_mode   (r_mode),
        .i_count  (r_count),
        .i_index  (r_index),
        .i_match  (w_match),
        .o_status (w_status),
        .o_pos    (w_pos)
    );

    assign w_row_p1 = {1'b0, r_req.row} + EXT_W'(1);
    assign w_col_p1 = {1'b0, r_req.col} + EXT_W'(1);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_row_span  <= EXT_W'(1);
            r_col_span  <= EXT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_row_span  <= n_row_span;
            r_col_span  <= n_col_span;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state, table totals and output handshake
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_row_span  = r_row_span;
        n_col_span  = r_col_span;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_mode == MODE_CLEAR) begin
                        n_count    = '0;
                        n_row_span = EXT_W'(1);
                        n_col_span = EXT_W'(1);
                    end else if (w_we) begin
                        n_count = r_count + CNT_W'(1);
                        if (w_row_p1 > r_row_span) n_row_span = w_row_p1;
                        if (w_col_p1 > r_col_span) n_col_span = w_col_p1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status <= w_status;
            if ((r_mode == MODE_READ) && (w_status == ST_OK)) begin
                r_rd <= w_rd;
            end else begin
                r_rd <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = CNT_OUT_W'(r_count);
    assign o_row_extent  = r_row_span;
    assign o_col_extent  = r_col_span;
    assign o_read_row    = r_rd.row;
    assign o_read_col    = r_rd.col;
    assign o_read_value  = r_rd.value;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("entry count above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_commit |=> $stable(r_count))
        else $error("entry count changed without a commit");

    a_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_count == CNT_W'($past(r_count) + CNT_W'(1))))
        else $error("successful add did not bump the count");

    a_empty_extents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_row_span == EXT_W'(1)) && (r_col_span == EXT_W'(1)))
        else $error("empty table with extents above one");

    a_result_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid && (r_state == S_IDLE))
        else $error("commit did not present a result");

endmodule

`default_nettype wire

// File: verif/sorted_sparse_entry_table_core_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_sparse_entry_table_core: directed, full-table, backpressure and
// random request streams, each result checked against a behavioral copy of the table.
// Depends on sset_pkg and the core RTL.

module sorted_sparse_entry_table_core_tb;
    import sset_pkg::*;

    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int MAX_REPORTS     = 10;
    localparam logic [ROW_W-1:0] MARK_ROW = 16'hBEEF;
    localparam logic [COL_W-1:0] MARK_COL = 16'h8000;

    typedef struct {
        t_mode            mode;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } table_req_t;

    typedef struct {
        t_status              status;
        logic [CNT_OUT_W-1:0] count;
        logic [EXT_W-1:0]     row_ext;
        logic [EXT_W-1:0]     col_ext;
        logic [ROW_W-1:0]     rd_row;
        logic [COL_W-1:0]     rd_col;
        logic [VAL_W-1:0]     rd_value;
    } table_res_t;

    // DUT inputs, known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [1:0]           i_mode      = '0;
    logic [ROW_W-1:0]     i_row       = '0;
    logic [COL_W-1:0]     i_col       = '0;
    logic [VAL_W-1:0]     i_value     = '0;
    logic [IDX_W-1:0]     i_index     = '0;
    logic                 i_out_stall = 1'b0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [STAT_W-1:0]    o_status;
    logic [CNT_OUT_W-1:0] o_entry_count;
    logic [EXT_W-1:0]     o_row_extent;
    logic [EXT_W-1:0]     o_col_extent;
    logic [ROW_W-1:0]     o_read_row;
    logic [COL_W-1:0]     o_read_col;
    logic [VAL_W-1:0]     o_read_value;

    // Table model state
    logic [ROW_W-1:0] model_rows [CAPACITY];
    logic [COL_W-1:0] model_cols [CAPACITY];
    logic [VAL_W-1:0] model_vals [CAPACITY];
    int               model_count    = 0;
    int               model_row_span = 1;
    int               model_col_span = 1;

    table_res_t table_results_q[$];
    int         error_count = 0;
    int         idle_cycles = 0;
    int         hold_len    = 0;
    bit         tx_steady   = 1'b0;
    bit         rx_steady   = 1'b0;

    sorted_sparse_entry_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .i_index       (i_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_row_extent  (o_row_extent),
        .o_col_extent  (o_col_extent),
        .o_read_row    (o_read_row),
        .o_read_col    (o_read_col),
        .o_read_value  (o_read_value)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Put an entry at pos, shifting later entries up, and grow the extents
    function automatic void place_entry(input int pos, input logic [ROW_W-1:0] r,
                                        input logic [COL_W-1:0] c,
                                        input logic [VAL_W-1:0] v);
        int k;
        for (k = model_count; k > pos; k--) begin
            model_rows[k] = model_rows[k-1];
            model_cols[k] = model_cols[k-1];
            model_vals[k] = model_vals[k-1];
        end
        model_rows[pos] = r;
        model_cols[pos] = c;
        model_vals[pos] = v;
        model_count++;
        if (int'(r) + 1 > model_row_span) model_row_span = int'(r) + 1;
        if (int'(c) + 1 > model_col_span) model_col_span = int'(c) + 1;
    endfunction

    // Apply one request to the table model and return the result it produces
    function automatic table_res_t apply_table_req(input table_req_t rq);
        table_res_t res;
        int         first;
        int         last;
        int         pos;
        int         k;
        bit         placed;
        res.status   = ST_OK;
        res.rd_row   = '0;
        res.rd_col   = '0;
        res.rd_value = '0;
        placed       = 1'b0;
        pos          = 0;
        case (rq.mode)
            MODE_CLEAR: begin
                model_count    = 0;
                model_row_span = 1;
                model_col_span = 1;
            end
            MODE_APPEND: begin
                if (model_count >= CAPACITY) res.status = ST_FULL;
                else place_entry(model_count, rq.row, rq.col, rq.value);
            end
            MODE_INSERT: begin
                // first run holding this row
                first = model_count;
                for (k = model_count - 1; k >= 0; k--)
                    if (model_rows[k] == rq.row) first = k;
                if (first >= model_count) begin
                    res.status = ST_ROW_ABSENT;
                end else begin
                    last = first;
                    while (last < model_count && model_rows[last] == rq.row) last++;
                    if (rq.col < model_cols[first]) begin
                        pos    = first;
                        placed = 1'b1;
                    end else if (rq.col > model_cols[last-1]) begin
                        pos    = last;
                        placed = 1'b1;
                    end else begin
                        // descending scan keeps the lowest matching gap
                        for (k = last - 2; k >= first; k--) begin
                            if (rq.col > model_cols[k] && rq.col < model_cols[k+1]) begin
                                pos    = k + 1;
                                placed = 1'b1;
                            end
                        end
                    end
                    if (!placed) res.status = ST_DUP_COL;
                    else if (model_count >= CAPACITY) res.status = ST_FULL;
                    else place_entry(pos, rq.row, rq.col, rq.value);
                end
            end
            MODE_READ: begin
                if (int'(rq.index) >= model_count) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    res.rd_row   = model_rows[rq.index];
                    res.rd_col   = model_cols[rq.index];
                    res.rd_value = model_vals[rq.index];
                end
            end
        endcase
        res.count   = CNT_OUT_W'(model_count);
        res.row_ext = EXT_W'(model_row_span);
        res.col_ext = EXT_W'(model_col_span);
        return res;
    endfunction

    function automatic table_req_t build_request(input t_mode m, input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c,
                                                 input logic [VAL_W-1:0] v,
                                                 input logic [IDX_W-1:0] idx);
        table_req_t rq;
        rq.mode  = m;
        rq.row   = r;
        rq.col   = c;
        rq.value = v;
        rq.index = idx;
        return rq;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Random request, steered toward rows and columns already in the table
    function automatic table_req_t random_request();
        table_req_t rq;
        int         pick;
        int         k;
        pick     = $urandom_range(0, 99);
        rq.value = {$urandom, $urandom};
        rq.index = IDX_W'($urandom);
        rq.row   = ($urandom_range(0, 1) == 0) ? ROW_W'($urandom_range(0, 7)) : ROW_W'($urandom);
        rq.col   = ($urandom_range(0, 1) == 0) ? COL_W'($urandom_range(0, 255))
                                                : COL_W'($urandom);
        if (pick < 4) rq.mode = MODE_CLEAR;
        else if (pick < 34) rq.mode = MODE_APPEND;
        else if (pick < 76) rq.mode = MODE_INSERT;
        else rq.mode = MODE_READ;
        if (model_count > 0) begin
            k = $urandom_range(0, model_count - 1);
            if (rq.mode == MODE_INSERT && $urandom_range(0, 4) != 0) begin
                rq.row = model_rows[k];
                case ($urandom_range(0, 3))
                    0: rq.col = model_cols[k];
                    1: rq.col = model_cols[k] + 1'b1;
                    2: rq.col = model_cols[k] - 1'b1;
                    default: ;
                endcase
            end
            if (rq.mode == MODE_READ && $urandom_range(0, 3) != 0) rq.index = IDX_W'(k);
        end
        return rq;
    endfunction

    // Offer one request after an optional gap; predict its result on acceptance
    task automatic send_request(input table_req_t rq);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= rq.mode;
        i_row      <= rq.row;
        i_col      <= rq.col;
        i_value    <= rq.value;
        i_index    <= rq.index;
        do @(posedge i_clk); while (o_in_stall);
        table_results_q.insert(table_results_q.size(), apply_table_req(rq));
    endtask

    task automatic test_directed_cases();
        // empty table: read and insert are both refused
        send_request(build_request(MODE_READ, 16'h0000, 16'h0000, 64'h0, 6'd0));
        send_request(build_request(MODE_INSERT, 16'h0005, 16'h0005, 64'h1, 6'd0));
        // field extremes
        send_request(build_request(MODE_APPEND, 16'h0000, 16'h0000, 64'h0, 6'd63));
        send_request(build_request(MODE_APPEND, 16'hFFFF, 16'hFFFF, '1, 6'd0));
        send_request(build_request(MODE_APPEND, 16'h1234, 16'd100, 64'hA5A5_5A5A_0F0F_F0F0,
                                   6'd0));
        // sorted insert ahead of the run, after it and between two columns
        send_request(build_request(MODE_INSERT, 16'h1234, 16'd50, 64'h1111, 6'd0));
        send_request(build_request(MODE_INSERT, 16'h1234, 16'd200, 64'h2222, 6'd0));
        send_request(build_request(MODE_INSERT, 16'h1234, 16'd150, 64'h3333, 6'd0));
        // duplicate column in the middle, at the start and at the end of the run
        send_request(build_request(MODE_INSERT, 16'h1234, 16'd100, 64'h4444, 6'd0));
        send_request(build_request(MODE_INSERT, 16'h1234, 16'd50, 64'h5555, 6'd0));
        send_request(build_request(MODE_INSERT, 16'h1234, 16'd200, 64'h6666, 6'd0));
        // row held nowhere in a non-empty table
        send_request(build_request(MODE_INSERT, 16'h0007, 16'd1, 64'h7777, 6'd0));
        // second run of row 0 further up; the insert must land in the first run
        send_request(build_request(MODE_INSERT, 16'h0000, 16'd1, 64'h8888, 6'd0));
        send_request(build_request(MODE_APPEND, 16'h0000, 16'd9, 64'h9999, 6'd0));
        send_request(build_request(MODE_INSERT, 16'h0000, 16'd5, 64'hAAAA, 6'd0));
        // reads: first, last, one past the end, top index
        send_request(build_request(MODE_READ, 16'hFFFF, 16'hFFFF, '1, 6'd0));
        send_request(build_request(MODE_READ, 16'h0, 16'h0, 64'h0, IDX_W'(model_count - 1)));
        send_request(build_request(MODE_READ, 16'h0, 16'h0, 64'h0, IDX_W'(model_count)));
        send_request(build_request(MODE_READ, 16'h0, 16'h0, 64'h0, 6'd63));
        // clear brings extents back to one
        send_request(build_request(MODE_CLEAR, 16'hFFFF, 16'hFFFF, '1, 6'd63));
        send_request(build_request(MODE_READ, 16'h0, 16'h0, 64'h0, 6'd0));
        send_request(build_request(MODE_INSERT, 16'h0000, 16'h0000, 64'h0, 6'd0));
    endtask

    task automatic test_full_table();
        table_req_t rq;
        int         k;
        send_request(build_request(MODE_CLEAR, 16'h0, 16'h0, 64'h0, 6'd0));
        // marker row whose run stays a single entry
        send_request(build_request(MODE_APPEND, MARK_ROW, MARK_COL, {$urandom, $urandom},
                                   6'd0));
        while (model_count < CAPACITY / 2)
            send_request(build_request(MODE_APPEND, ROW_W'($urandom_range(1, 6)),
                                       COL_W'($urandom), {$urandom, $urandom},
                                       IDX_W'($urandom)));
        // fill the rest by sorted inserts into the small rows
        while (model_count < CAPACITY) begin
            k  = $urandom_range(0, model_count - 1);
            rq = build_request(MODE_INSERT, model_rows[k], COL_W'($urandom),
                               {$urandom, $urandom}, IDX_W'($urandom));
            if (rq.row == MARK_ROW) rq.row = 16'd1;
            send_request(rq);
        end
        // full table: append and placeable insert refused, other checks come first
        send_request(build_request(MODE_APPEND, 16'h0001, 16'h0001, '1, 6'd0));
        send_request(build_request(MODE_INSERT, MARK_ROW, 16'h0001, '1, 6'd0));
        send_request(build_request(MODE_INSERT, MARK_ROW, MARK_COL, '1, 6'd0));
        send_request(build_request(MODE_INSERT, 16'hFFFF, 16'h0000, '1, 6'd0));
        send_request(build_request(MODE_READ, 16'h0, 16'h0, 64'h0, 6'd63));
        send_request(build_request(MODE_READ, 16'h0, 16'h0, 64'h0, 6'd0));
        send_request(build_request(MODE_CLEAR, 16'h0, 16'h0, 64'h0, 6'd0));
    endtask

    // Receiver holds off while requests keep coming, so the core backs up
    task automatic test_backpressure();
        int i;
        tx_steady = 1'b1;
        hold_len  = HOLD_CYCLES;
        for (i = 0; i < 24; i++) begin
            if (i % 3 == 2)
                send_request(build_request(MODE_READ, 16'h0, 16'h0, 64'h0,
                                           IDX_W'($urandom_range(0, 15))));
            else
                send_request(build_request(MODE_APPEND, ROW_W'($urandom), COL_W'($urandom),
                                           {$urandom, $urandom}, 6'd0));
        end
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            send_request(build_request(MODE_CLEAR, ROW_W'($urandom), COL_W'($urandom),
                                       {$urandom, $urandom}, IDX_W'($urandom)));
            burst = $urandom_range(20, 90);
            repeat (burst) send_request(random_request());
            sent += burst + 1;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver stall: random stretches, plus a long hold-off on request
    initial begin : receiver_stall
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat (rx_steady ? 1 : $urandom_range(1, 4)) @(posedge i_clk);
            n = rx_steady ? 0 : pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        table_res_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (table_results_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d count %0d", o_status,
                             o_entry_count);
            end else begin
                want = table_results_q.pop_front();
                if (o_status !== want.status || o_entry_count !== want.count ||
                    o_row_extent !== want.row_ext || o_col_extent !== want.col_ext ||
                    o_read_row !== want.rd_row || o_read_col !== want.rd_col ||
                    o_read_value !== want.rd_value) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch at %0t: expected st %0d cnt %0d ext %0d/%0d rd %h %h %h",
                                 $realtime, want.status, want.count, want.row_ext,
                                 want.col_ext, want.rd_row, want.rd_col, want.rd_value);
                        $display("                 actual   st %0d cnt %0d ext %0d/%0d rd %h %h %h",
                                 o_status, o_entry_count, o_row_extent, o_col_extent,
                                 o_read_row, o_read_col, o_read_value);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sorted_sparse_entry_table_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_full_table();
        test_backpressure();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (table_results_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && table_results_q.size() == 0)
            $display("sorted_sparse_entry_table_core verification clean");
        else
            $display("sorted_sparse_entry_table_core verification failed");
        $finish;
    end

endmodule
